FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion forms used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, held off during reset.
`define ASSERT_CLK(label, clk_sig, rst_n, prop, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n) prop) else $error(msg);

// Implication checked on every rising edge, held off during reset.
`define ASSERT_IMPL(label, clk_sig, rst_n, ante, cons, msg) \
	`ASSERT_CLK(label, clk_sig, rst_n, (ante) |-> (cons), msg)

`endif

FILE: sv/tte_pkg.sv
// ----------------------------------------------------------------------------
// tte_pkg
// Widths, angle constants and the arctangent table of the time estimator.
// ----------------------------------------------------------------------------
package tte_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int TABLE_LEN    = 24;

	// CORDIC datapath: 42-bit prescaled operands plus gain headroom
	localparam int CW = 44;
	// Q.24 angle with room for pi plus the full table sum
	localparam int ZW = 28;

	localparam logic signed [ZW-1:0] ANG_PI     = 28'sd52707179;
	localparam logic signed [ZW:0]   ANG_PI_W   = 29'sd52707179;
	localparam logic signed [ZW:0]   ANG_TWO_PI = 29'sd105414357;
	localparam logic [19:0]          INV_GAIN   = 20'd636751;

	localparam logic [7:0] REG_SEC_PER_METER  = 8'd0;
	localparam logic [7:0] REG_SEC_PER_RADIAN = 8'd1;

	localparam logic signed [ZW-1:0] ATAN_TAB [0:TABLE_LEN-1] = '{
		28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331,
		28'sd1047214,  28'sd524117,  28'sd262123,  28'sd131069,
		28'sd65536,    28'sd32768,   28'sd16384,   28'sd8192,
		28'sd4096,     28'sd2048,    28'sd1024,    28'sd512,
		28'sd256,      28'sd128,     28'sd64,      28'sd32,
		28'sd16,       28'sd8,       28'sd4,       28'sd2
	};

	typedef struct packed {
		logic                 zero;
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [ZW-1:0] z;
	} vec_t;

endpackage

FILE: sv/turn_and_drive_time_estimate.sv
// ----------------------------------------------------------------------------
// turn_and_drive_time_estimate
// Range and bearing to a goal plus quaternion yaw, by two CORDIC pipelines.
// ----------------------------------------------------------------------------
// Each input beat passes the stages in order, from the offset and quaternion products to the output register.
// Throughput: one beat per cycle while the output is not stalled; each CORDIC iteration is its own stage.
// Every stage advances together when the output register is empty or taken.
// Reset clears all valid bits and loads both registers with 1.0 (Q8.16).
module turn_and_drive_time_estimate (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// goal_x, goal_y, pose_x, pose_y, quat_x, quat_y, quat_z, quat_w
	input  logic [191:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// time_to_target
	output logic [31:0]  m_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [7:0]   cfg_index,
	input  logic [23:0]  cfg_data
);

	localparam int N  = tte_pkg::CORDIC_STEPS;
	localparam int CW = tte_pkg::CW;
	localparam int ZW = tte_pkg::ZW;

	logic        en;
	logic [23:0] sec_per_meter_q;
	logic [23:0] sec_per_radian_q;

	assign en        = !m_tvalid || m_tready;
	assign s_tready  = en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_per_meter_q  <= 24'd65536;
			sec_per_radian_q <= 24'd65536;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				tte_pkg::REG_SEC_PER_METER:  sec_per_meter_q  <= cfg_data;
				tte_pkg::REG_SEC_PER_RADIAN: sec_per_radian_q <= cfg_data;
				default: ;
			endcase
		end
	end

	function automatic tte_pkg::vec_t vec_init(logic signed [CW-1:0] x,
	                                           logic signed [CW-1:0] y);
		tte_pkg::vec_t v;
		v.zero = (x == '0) && (y == '0);
		if (x < 0) begin
			v.x = -x;
			v.y = -y;
			v.z = (y >= 0) ? tte_pkg::ANG_PI : -tte_pkg::ANG_PI;
		end else begin
			v.x = x;
			v.y = y;
			v.z = '0;
		end
		return v;
	endfunction

	function automatic tte_pkg::vec_t vec_step(tte_pkg::vec_t v, int i);
		tte_pkg::vec_t r;
		r.zero = v.zero;
		if (v.y >= 0) begin
			r.x = v.x + (v.y >>> i);
			r.y = v.y - (v.x >>> i);
			r.z = v.z + tte_pkg::ATAN_TAB[i];
		end else begin
			r.x = v.x - (v.y >>> i);
			r.y = v.y + (v.x >>> i);
			r.z = v.z - tte_pkg::ATAN_TAB[i];
		end
		return r;
	endfunction

	// ---------------- stage 1: offset and quaternion products --------------
	logic               v_s1;
	logic signed [32:0] dx_s1, dy_s1;
	logic signed [31:0] wz_s1, xy_s1, yy_s1, zz_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= 33'(signed'(s_tdata[31:0]))  - 33'(signed'(s_tdata[95:64]));
			dy_s1 <= 33'(signed'(s_tdata[63:32])) - 33'(signed'(s_tdata[127:96]));
			wz_s1 <= signed'(s_tdata[191:176]) * signed'(s_tdata[175:160]);
			xy_s1 <= signed'(s_tdata[143:128]) * signed'(s_tdata[159:144]);
			yy_s1 <= signed'(s_tdata[159:144]) * signed'(s_tdata[159:144]);
			zz_s1 <= signed'(s_tdata[175:160]) * signed'(s_tdata[175:160]);
		end
	end

	// ---------------- stage 2: yaw operands, prescale, half-turn -----------
	logic signed [33:0] yaw_a, yaw_b;
	logic               v_sk [0:N];
	tte_pkg::vec_t      brg_sk [0:N];
	tte_pkg::vec_t      yaw_sk [0:N];

	assign yaw_a = (34'(wz_s1) + 34'(xy_s1)) <<< 1;
	assign yaw_b = 34'sd268435456 - ((34'(yy_s1) + 34'(zz_s1)) <<< 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_sk[0] <= 1'b0;
		else if (en) v_sk[0] <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			brg_sk[0] <= vec_init(CW'(dx_s1) <<< 8, CW'(dy_s1) <<< 8);
			yaw_sk[0] <= vec_init(CW'(yaw_b) <<< 8, CW'(yaw_a) <<< 8);
		end
	end

	// ---------------- CORDIC iterations, one stage each --------------------
	for (genvar gi = 0; gi < N; gi++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_sk[gi+1] <= 1'b0;
			else if (en) v_sk[gi+1] <= v_sk[gi];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				brg_sk[gi+1] <= vec_step(brg_sk[gi], gi);
				yaw_sk[gi+1] <= vec_step(yaw_sk[gi], gi);
			end
		end
	end

	// ---------------- stage 3: heading error, range partial products -------
	logic signed [ZW-1:0] bearing, yaw;
	logic signed [ZW:0]   err_raw, err_wrap;
	logic [CW-1:0]        mag;
	logic                 v_s3;
	logic [25:0]          err_s3;
	logic [41:0]          mlo_s3, mhi_s3;

	assign bearing = brg_sk[N].zero ? '0 : brg_sk[N].z;
	assign yaw     = yaw_sk[N].zero ? '0 : yaw_sk[N].z;
	assign mag     = brg_sk[N].zero ? '0 : brg_sk[N].x;
	assign err_raw = (ZW+1)'(bearing) - (ZW+1)'(yaw);

	always_comb begin
		if (err_raw >= tte_pkg::ANG_PI_W) err_wrap = err_raw - tte_pkg::ANG_TWO_PI;
		else if (err_raw < -tte_pkg::ANG_PI_W) err_wrap = err_raw + tte_pkg::ANG_TWO_PI;
		else err_wrap = err_raw;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_sk[N];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			err_s3 <= err_wrap[ZW] ? 26'(-err_wrap) : 26'(err_wrap);
			mlo_s3 <= 42'(mag[21:0]) * 42'(tte_pkg::INV_GAIN);
			mhi_s3 <= 42'(mag[CW-1:22]) * 42'(tte_pkg::INV_GAIN);
		end
	end

	// ---------------- stage 4: range rounding, turn time -------------------
	logic [65:0] prod;
	logic [49:0] ang_full;
	logic        v_s4;
	logic [34:0] range_s4;
	logic [41:0] ang_s4;

	assign prod     = (66'(mhi_s3) << 22) + 66'(mlo_s3) + (66'd1 << 27);
	assign ang_full = 50'(err_s3) * 50'(sec_per_radian_q) + 50'd128;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			range_s4 <= prod[62:28];
			ang_s4   <= ang_full[49:8];
		end
	end

	// ---------------- stage 5: drive time partial products -----------------
	logic        v_s5;
	logic [41:0] llo_s5;
	logic [40:0] lhi_s5;
	logic [41:0] ang_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (en) v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			llo_s5 <= 42'(range_s4[17:0]) * 42'(sec_per_meter_q);
			lhi_s5 <= 41'(range_s4[34:18]) * 41'(sec_per_meter_q);
			ang_s5 <= ang_s4;
		end
	end

	// ---------------- stage 6: sum, round, saturate into output ------------
	logic [59:0] total;
	logic [31:0] time_s6;

	assign total = 60'(llo_s5) + (60'(lhi_s5) << 18) + 60'(ang_s5) + 60'd32768;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_tvalid <= 1'b0;
		else if (en) m_tvalid <= v_s5;
	end

	always_ff @(posedge clk) begin
		if (en) time_s6 <= (total[59:48] != '0) ? 32'hFFFF_FFFF : total[47:16];
	end

	assign m_tdata = time_s6;

endmodule

FILE: sv/tte_checker.sv
// ----------------------------------------------------------------------------
// tte_checker
// Port-level checks of the time estimator, bound to its top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tte_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic [191:0] s_tdata,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [31:0]  m_tdata,
	input logic         cfg_valid,
	input logic         cfg_ready,
	input logic [7:0]   cfg_index,
	input logic [23:0]  cfg_data
);

	logic unused_ok;
	assign unused_ok = ^{s_tvalid, s_tdata, cfg_index, cfg_data};

	// a stalled result beat stays offered and unchanged
	`ASSERT_CLK(a_out_hold, clk, arst_n, (m_tvalid && !m_tready) |=> m_tvalid, "result beat dropped under stall")
	`ASSERT_CLK(a_out_stable, clk, arst_n, (m_tvalid && !m_tready) |=> $stable(m_tdata), "result beat changed under stall")
	// an empty or accepted output stage must never hold back the input
	`ASSERT_IMPL(a_flow, clk, arst_n, !m_tvalid || m_tready, s_tready, "input stalled with output free")
	`ASSERT_IMPL(a_cfg_rdy, clk, arst_n, cfg_valid, cfg_ready, "register write refused")

endmodule

bind turn_and_drive_time_estimate tte_checker u_tte_checker (.*);

FILE: sim/tb_turn_and_drive_time_estimate.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_turn_and_drive_time_estimate
// Streams goal and pose beats through the time estimator under random gaps
// and output stalls, predicts each time in fixed point and compares in order.
// ----------------------------------------------------------------------------
module tb_turn_and_drive_time_estimate;

	localparam longint PI_Q24     = 52707179;
	localparam longint TWO_PI_Q24 = 105414357;
	localparam int     LIMIT      = 400000;

	typedef struct {
		logic signed [31:0] gx, gy, px, py;
		logic signed [15:0] qx, qy, qz, qw;
	} pose_goal_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [191:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [31:0]  m_tdata;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [7:0]   cfg_index;
	logic [23:0]  cfg_data;

	logic [23:0]  spm, spr;
	logic [31:0]  times_due[$];
	int           errors;
	int           cycles;
	bit           hold_off;
	bit           no_gaps;

	turn_and_drive_time_estimate u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic longint floor_shr(longint v, int s);
		return v >>> s;
	endfunction

	// angle in Q.24 and gain-scaled magnitude (x256) of (x,y)
	function automatic void vector_angle(input longint x0, input longint y0,
			output longint ang, output longint mag);
		longint x, y, z, xs, ys;
		x = x0 * 256;
		y = y0 * 256;
		z = 0;
		if (x0 == 0 && y0 == 0) begin
			ang = 0;
			mag = 0;
			return;
		end
		if (x < 0) begin
			z = (y >= 0) ? PI_Q24 : -PI_Q24;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < tte_pkg::CORDIC_STEPS && i < tte_pkg::TABLE_LEN; i++) begin
			xs = floor_shr(x, i);
			ys = floor_shr(y, i);
			if (y >= 0) begin
				x += ys; y -= xs; z += longint'(tte_pkg::ATAN_TAB[i]);
			end else begin
				x -= ys; y += xs; z -= longint'(tte_pkg::ATAN_TAB[i]);
			end
		end
		ang = z;
		mag = x;
	endfunction

	function automatic logic [31:0] travel_time(pose_goal_t p);
		longint bearing, mag, yaw, ymag, err, a, b;
		longint qx, qy, qz, qw;
		logic [63:0] range, lin, turn, sum;
		vector_angle(longint'(p.gx) - longint'(p.px), longint'(p.gy) - longint'(p.py),
			bearing, mag);
		range = (64'(mag) * 64'd636751 + (64'd1 << 27)) >> 28;
		qx = longint'(p.qx); qy = longint'(p.qy);
		qz = longint'(p.qz); qw = longint'(p.qw);
		a = 2 * (qw * qz + qx * qy);
		b = (longint'(1) << 28) - 2 * (qy * qy + qz * qz);
		vector_angle(b, a, yaw, ymag);
		err = bearing - yaw;
		while (err >= PI_Q24) err -= TWO_PI_Q24;
		while (err < -PI_Q24) err += TWO_PI_Q24;
		if (err < 0) err = -err;
		lin = range * 64'(spm);
		turn = (64'(err) * 64'(spr) + 64'd128) >> 8;
		sum = (lin + turn + 64'd32768) >> 16;
		return (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
	endfunction

	// drop valid only when a gap follows, so back-to-back beats keep it high
	task automatic idle_gap();
		int n;
		if (no_gaps) return;
		n = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
		if (n != 0) begin
			s_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic send_pose(pose_goal_t p);
		idle_gap();
		s_tdata  <= {p.qw, p.qz, p.qy, p.qx, p.py, p.px, p.gy, p.gx};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		times_due = {times_due, travel_time(p)};
	endtask

	task automatic write_reg(logic [7:0] idx, logic [23:0] val);
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == tte_pkg::REG_SEC_PER_METER) spm = val;
		else if (idx == tte_pkg::REG_SEC_PER_RADIAN) spr = val;
		@(posedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (times_due.size() != 0) @(posedge clk);
		repeat (tte_pkg::CORDIC_STEPS + 10) @(posedge clk);
	endtask

	function automatic pose_goal_t random_pose();
		pose_goal_t p;
		int unit;
		p.gx = $urandom; p.gy = $urandom; p.px = $urandom; p.py = $urandom;
		unit = $urandom_range(0, 3);
		if (unit != 0) begin
			// keep most offsets modest so the drive part does not always saturate
			p.px = $signed($urandom) >>> $urandom_range(4, 16);
			p.py = $signed($urandom) >>> $urandom_range(4, 16);
			p.gx = p.px + ($signed($urandom) >>> $urandom_range(8, 20));
			p.gy = p.py + ($signed($urandom) >>> $urandom_range(8, 20));
		end
		if ($urandom_range(0, 3) == 0) begin
			p.qx = 16'($urandom); p.qy = 16'($urandom);
			p.qz = 16'($urandom); p.qw = 16'($urandom);
		end else begin
			// planar rotation from random qz, qw with a little roll/pitch noise
			p.qz = 16'($urandom_range(0, 32767) - 16384);
			p.qw = 16'($urandom_range(0, 32767) - 16384);
			p.qx = 16'($urandom_range(0, 511) - 256);
			p.qy = 16'($urandom_range(0, 511) - 256);
		end
		return p;
	endfunction

	task automatic test_directed();
		pose_goal_t p;
		logic signed [31:0] ext[4] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF};
		logic signed [15:0] qe[4] = '{16'h8000, 16'h7FFF, 16'h0, 16'h4000};
		// goal on pose, unit quaternion
		p = '{default: 0};
		p.qw = 16'h4000;
		send_pose(p);
		// degenerate quaternion
		p.gx = 32'h0001_0000;
		p.qw = '0;
		send_pose(p);
		for (int i = 0; i < 16; i++) begin
			p.gx = ext[i % 4]; p.gy = ext[(i / 4) % 4];
			p.px = ext[(i + 1) % 4]; p.py = ext[(i + 2) % 4];
			p.qx = qe[i % 4]; p.qy = qe[(i + 3) % 4];
			p.qz = qe[(i / 4) % 4]; p.qw = qe[(i + 1) % 4];
			send_pose(p);
		end
		// goal behind: negative x offset with y above, below and on the axis
		p = '{default: 0};
		p.qw = 16'h4000;
		p.gx = -32'sh0003_0000; p.gy = 32'sh0000_0001;
		send_pose(p);
		p.gy = -32'sh0000_0001;
		send_pose(p);
		p.gy = '0;
		send_pose(p);
		drain();
	endtask

	task automatic test_random(int n);
		for (int i = 0; i < n; i++) send_pose(random_pose());
		drain();
	endtask

	task automatic test_backpressure();
		no_gaps = 1'b1;
		hold_off = 1'b1;
		fork
			begin
				repeat (200) @(posedge clk);
				hold_off = 1'b0;
			end
			for (int i = 0; i < 80; i++) send_pose(random_pose());
		join
		no_gaps = 1'b0;
		drain();
	endtask

	task automatic test_registers();
		logic [23:0] spm_set[4] = '{24'd0, 24'hFFFFFF, 24'd1, 24'd65536};
		logic [23:0] spr_set[4] = '{24'hFFFFFF, 24'd0, 24'd200000, 24'd65536};
		for (int k = 0; k < 4; k++) begin
			write_reg(tte_pkg::REG_SEC_PER_METER, spm_set[k]);
			write_reg(tte_pkg::REG_SEC_PER_RADIAN, spr_set[k]);
			write_reg(8'hA5, 24'($urandom));
			test_random(150);
		end
		for (int k = 0; k < 3; k++) begin
			write_reg(tte_pkg::REG_SEC_PER_METER, 24'($urandom_range(0, 24'hFFFFFF)));
			write_reg(tte_pkg::REG_SEC_PER_RADIAN, 24'($urandom_range(0, 24'hFFFFFF)));
			test_random(150);
		end
		write_reg(tte_pkg::REG_SEC_PER_METER, 24'd65536);
		write_reg(tte_pkg::REG_SEC_PER_RADIAN, 24'd65536);
	endtask

	// output side: random stall, hold during the back-pressure test
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_off) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 9) < 7) || no_gaps;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (times_due.size() == 0) begin
				$error("time_to_target beat with nothing expected: %h", m_tdata);
				errors++;
			end else begin
				logic [31:0] want;
				want = times_due.pop_front();
				if (m_tdata !== want) begin
					$error("time_to_target expected %h actual %h", want, m_tdata);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		errors = 0; cycles = 0; hold_off = 1'b0; no_gaps = 1'b0;
		spm = 24'd65536; spr = 24'd65536;
		s_tvalid = 1'b0; s_tdata = '0;
		cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_random(700);
		test_registers();
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule
